FILE: rtl/wrsn_pkg.sv
// Shared types, constants and helpers for the WPA/RSN element parser.
package wrsn_pkg;

    // Field widths of the byte and record words
    localparam int BYTE_W  = 8;
    localparam int REM_W   = 16;
    localparam int KIND_W  = 3;
    localparam int CODE_W  = 3;
    localparam int VER_W   = 16;
    localparam int IKIND_W = 2;

    // Records one byte can cause at most, and default group queue depth
    localparam int MAX_REC   = 4;
    localparam int REC_N_W   = $clog2(MAX_REC + 1);
    localparam int GRP_DEPTH = 4;

    // Element ids and WPA vendor type
    localparam logic [BYTE_W-1:0] ID_RSN   = 8'h30;
    localparam logic [BYTE_W-1:0] ID_WPA   = 8'hdd;
    localparam logic [BYTE_W-1:0] WPA_TYPE = 8'h01;

    // Element kinds
    localparam logic [IKIND_W-1:0] IK_NONE = 2'd0;
    localparam logic [IKIND_W-1:0] IK_WPA  = 2'd1;
    localparam logic [IKIND_W-1:0] IK_RSN  = 2'd2;

    // Record kinds
    localparam logic [KIND_W-1:0] REC_HDR  = 3'd0;
    localparam logic [KIND_W-1:0] REC_GRP  = 3'd1;
    localparam logic [KIND_W-1:0] REC_PAIR = 3'd2;
    localparam logic [KIND_W-1:0] REC_AKM  = 3'd3;
    localparam logic [KIND_W-1:0] REC_END  = 3'd4;

    // Suite codes
    localparam logic [CODE_W-1:0] CODE_NONE    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_TKIP    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN = 3'd6;
    localparam logic [CODE_W-1:0] CODE_PROP    = 3'd7;
    localparam logic [BYTE_W-1:0] CIPHER_KNOWN = 8'd6;
    localparam logic [BYTE_W-1:0] AKM_KNOWN    = 8'd3;

    // Parser phase
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_LEN  = 4'd1,
        PH_WOUI = 4'd2,
        PH_VLO  = 4'd3,
        PH_VHI  = 4'd4,
        PH_GRP  = 4'd5,
        PH_PLO  = 4'd6,
        PH_PHI  = 4'd7,
        PH_PSU  = 4'd8,
        PH_ALO  = 4'd9,
        PH_AHI  = 4'd10,
        PH_ASU  = 4'd11
    } t_phase;

    // One result record
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CODE_W-1:0]  code;
        logic [VER_W-1:0]   ver;
        logic [IKIND_W-1:0] ikind;
        logic               last;
    } t_rec;

    // All records caused by one byte
    typedef struct packed {
        logic [REC_N_W-1:0]       n;
        t_rec [MAX_REC-1:0]       rec;
    } t_group;

    function automatic t_rec mk_rec(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                    logic [VER_W-1:0] ver, logic [IKIND_W-1:0] ikind,
                                    logic last);
        t_rec r;
        r.kind  = kind;
        r.code  = code;
        r.ver   = ver;
        r.ikind = ikind;
        r.last  = last;
        return r;
    endfunction

    // Suite OUI byte: 00-0F-AC for RSN, 00-50-F2 for WPA
    function automatic logic [BYTE_W-1:0] oui_byte(logic is_rsn, logic [1:0] idx);
        logic [BYTE_W-1:0] v;
        case (idx)
            2'd0:    v = 8'h00;
            2'd1:    v = is_rsn ? 8'h0f : 8'h50;
            2'd2:    v = is_rsn ? 8'hac : 8'hf2;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Decode a suite type byte against the collected OUI match
    function automatic logic [CODE_W-1:0] suite_code(logic oui_ok, logic [BYTE_W-1:0] b,
                                                     logic [BYTE_W-1:0] known);
        logic [CODE_W-1:0] c;
        if (!oui_ok)
            c = CODE_PROP;
        else if (b < known)
            c = b[CODE_W-1:0];
        else
            c = CODE_UNKNOWN;
        return c;
    endfunction

endpackage

FILE: rtl/wrsn_if.sv
// Valid/ready channel interfaces for element bytes and parsed records.
interface wrsn_in_if;
    logic                           valid;
    logic                           ready;
    logic [wrsn_pkg::BYTE_W-1:0]    ie_byte;
    logic                           elem_start;
    logic [wrsn_pkg::REM_W-1:0]     bytes_remaining;

    modport source (output valid, ie_byte, elem_start, bytes_remaining, input ready);
    modport sink   (input valid, ie_byte, elem_start, bytes_remaining, output ready);
endinterface

interface wrsn_out_if;
    logic                           valid;
    logic                           ready;
    logic [wrsn_pkg::KIND_W-1:0]    record_kind;
    logic [wrsn_pkg::CODE_W-1:0]    suite_code;
    logic [wrsn_pkg::VER_W-1:0]     ie_version;
    logic [wrsn_pkg::IKIND_W-1:0]   ie_kind;
    logic                           last_record;

    modport source (output valid, record_kind, suite_code, ie_version, ie_kind, last_record,
                    input ready);
    modport sink   (input valid, record_kind, suite_code, ie_version, ie_kind, last_record,
                    output ready);
endinterface

FILE: rtl/wpa_rsn_ie_parser.sv
// WPA/RSN information element parser: byte register, parse step, record group queue.
//
//  channel  | dir | word                                         | accepted when
//  ---------+-----+----------------------------------------------+---------------------
//  i_in     | in  | ie_byte, elem_start, bytes_remaining         | valid && ready
//  o_out    | out | record_kind, suite_code, ie_version, ie_kind,| valid && ready
//           |     | last_record                                  |
//
// One byte per cycle while i_in.ready is high: a byte is registered, then parsed in the
// next cycle, and the 0 to 4 records it causes go as one group into a queue of GRP_DEPTH
// groups. Records leave one per cycle while o_out.ready is high; i_in.ready comes from the
// queue fill count alone (room for two groups). The first record of a byte can be taken
// once the byte has passed the byte register and its group has been written to the queue.
// Reset (synchronous, active low) empties the queue and returns the parser to idle.
// A stalled output only slows input once the queue holds more than GRP_DEPTH-2 groups.
module wpa_rsn_ie_parser #(
    parameter int GRP_DEPTH = wrsn_pkg::GRP_DEPTH  // power of two, at least 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wrsn_in_if.sink     i_in,
    wrsn_out_if.source  o_out
);

    localparam int PTR_W = (GRP_DEPTH > 1) ? $clog2(GRP_DEPTH) : 1;
    localparam int CNT_W = $clog2(GRP_DEPTH + 1);
    localparam int CMP_W = wrsn_pkg::REM_W + 3;

    // Input byte register
    logic                           r_in_vld;
    logic [wrsn_pkg::BYTE_W-1:0]    r_b;
    logic                           r_start;
    logic [wrsn_pkg::REM_W-1:0]     r_rem;

    // Parser state
    logic [15:0]                    r_bo,   n_bo;
    logic [15:0]                    r_len,  n_len;
    wrsn_pkg::t_phase               r_phase, n_phase;
    logic [wrsn_pkg::IKIND_W-1:0]   r_kind, n_kind;
    logic [15:0]                    r_sc,   n_sc;
    logic                           r_oui,  n_oui;
    logic [7:0]                     r_low,  n_low;

    // Group queue
    wrsn_pkg::t_group               r_grp [GRP_DEPTH];
    logic [PTR_W-1:0]               r_wp, r_rp;
    logic [CNT_W-1:0]               r_cnt;
    logic [1:0]                     r_idx;

    // Parse step signals
    wrsn_pkg::t_group               g;
    logic                           fin, fin_rej;
    logic [15:0]                    bo_inc;
    logic [CMP_W-1:0]               len_x, next_x, cnt4_x;
    logic [15:0]                    cnt;
    logic [8:0]                     len_byte;
    logic [15:0]                    len_clamp;
    logic [1:0]                     pos;
    logic                           is_rsn;
    logic                           push, pop;
    wrsn_pkg::t_group               head;

    function automatic wrsn_pkg::t_group push_rec(wrsn_pkg::t_group gi, wrsn_pkg::t_rec r);
        wrsn_pkg::t_group go;
        go = gi;
        go.rec[gi.n[1:0]] = r;
        go.n = gi.n + wrsn_pkg::REC_N_W'(1);
        return go;
    endfunction

    assign i_in.ready = (r_cnt <= CNT_W'(GRP_DEPTH - 2));

    // Input byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_in.valid && i_in.ready;
        end
        if (i_in.valid && i_in.ready) begin
            r_b     <= i_in.ie_byte;
            r_start <= i_in.elem_start;
            r_rem   <= i_in.bytes_remaining;
        end
    end

    // Shared terms of the parse step
    assign bo_inc    = r_bo + 16'd1;
    assign next_x    = CMP_W'(bo_inc) + CMP_W'(1);
    assign len_x     = CMP_W'(r_len);
    assign cnt       = {r_b, r_low};
    assign cnt4_x    = CMP_W'({cnt, 2'b00});
    assign len_byte  = {1'b0, r_b} + 9'd2;
    assign len_clamp = (16'(len_byte) > r_len) ? r_len : 16'(len_byte);
    assign is_rsn    = (r_kind == wrsn_pkg::IK_RSN);

    always_comb begin
        unique case (r_phase)
            wrsn_pkg::PH_WOUI: pos = bo_inc[1:0] - 2'd2;
            wrsn_pkg::PH_PSU:  pos = bo_inc[1:0] + 2'd2;
            default:           pos = bo_inc[1:0];
        endcase
    end

    // Parse step: next state and the record group of the registered byte
    always_comb begin
        n_bo    = r_bo;
        n_len   = r_len;
        n_phase = r_phase;
        n_kind  = r_kind;
        n_sc    = r_sc;
        n_oui   = r_oui;
        n_low   = r_low;
        g       = '0;
        fin     = 1'b0;
        fin_rej = 1'b0;

        if (r_start) begin
            n_bo  = '0;
            n_sc  = '0;
            n_oui = 1'b1;
            n_low = '0;
            if (r_b == wrsn_pkg::ID_RSN || r_b == wrsn_pkg::ID_WPA) begin
                n_kind = (r_b == wrsn_pkg::ID_RSN) ? wrsn_pkg::IK_RSN : wrsn_pkg::IK_WPA;
                if (r_rem < 16'd2) begin
                    fin     = 1'b1;
                    fin_rej = 1'b1;
                end else begin
                    n_len   = r_rem;
                    n_phase = wrsn_pkg::PH_LEN;
                end
            end else begin
                fin     = 1'b1;
                fin_rej = 1'b1;
            end
        end else if (r_phase != wrsn_pkg::PH_IDLE) begin
            n_bo = bo_inc;
            unique case (r_phase) inside
                wrsn_pkg::PH_LEN: begin
                    n_len = len_clamp;
                    if (is_rsn) begin
                        if (len_clamp < 16'd4) begin
                            fin = 1'b1; fin_rej = 1'b1;
                        end else begin
                            n_phase = wrsn_pkg::PH_VLO;
                        end
                    end else if (len_clamp < 16'd8) begin
                        fin = 1'b1; fin_rej = 1'b1;
                    end else begin
                        n_oui   = 1'b1;
                        n_phase = wrsn_pkg::PH_WOUI;
                    end
                end
                wrsn_pkg::PH_WOUI: begin
                    if (pos != 2'd3) begin
                        n_oui = r_oui && (r_b == wrsn_pkg::oui_byte(1'b0, pos));
                    end else if (!r_oui || r_b != wrsn_pkg::WPA_TYPE) begin
                        fin = 1'b1; fin_rej = 1'b1;
                    end else begin
                        n_phase = wrsn_pkg::PH_VLO;
                    end
                end
                wrsn_pkg::PH_VLO, wrsn_pkg::PH_PLO, wrsn_pkg::PH_ALO: begin
                    n_low = r_b;
                    case (r_phase)
                        wrsn_pkg::PH_VLO: n_phase = wrsn_pkg::PH_VHI;
                        wrsn_pkg::PH_PLO: n_phase = wrsn_pkg::PH_PHI;
                        default:          n_phase = wrsn_pkg::PH_AHI;
                    endcase
                end
                wrsn_pkg::PH_VHI: begin
                    g = push_rec(g, wrsn_pkg::mk_rec(wrsn_pkg::REC_HDR, wrsn_pkg::CODE_NONE,
                                                     {r_b, r_low}, r_kind, 1'b0));
                    if (len_x < next_x + CMP_W'(4)) begin
                        // no room for a group suite: TKIP defaults
                        g = push_rec(g, wrsn_pkg::mk_rec(wrsn_pkg::REC_GRP, wrsn_pkg::CODE_TKIP,
                                                         '0, r_kind, 1'b0));
                        g = push_rec(g, wrsn_pkg::mk_rec(wrsn_pkg::REC_PAIR,
                                                         wrsn_pkg::CODE_TKIP, '0, r_kind, 1'b0));
                        fin = 1'b1;
                    end else begin
                        n_oui   = 1'b1;
                        n_phase = wrsn_pkg::PH_GRP;
                    end
                end
                wrsn_pkg::PH_GRP, wrsn_pkg::PH_PSU, wrsn_pkg::PH_ASU: begin
                    if (pos == 2'd0) begin
                        n_oui = (r_b == wrsn_pkg::oui_byte(is_rsn, pos));
                    end else if (pos != 2'd3) begin
                        n_oui = r_oui && (r_b == wrsn_pkg::oui_byte(is_rsn, pos));
                    end else begin
                        case (r_phase)
                            wrsn_pkg::PH_GRP: begin
                                g = push_rec(g, wrsn_pkg::mk_rec(wrsn_pkg::REC_GRP,
                                    wrsn_pkg::suite_code(r_oui, r_b, wrsn_pkg::CIPHER_KNOWN),
                                    '0, r_kind, 1'b0));
                                if (len_x < next_x + CMP_W'(2)) begin
                                    // no room for a pairwise count
                                    g = push_rec(g, wrsn_pkg::mk_rec(wrsn_pkg::REC_PAIR,
                                        wrsn_pkg::CODE_TKIP, '0, r_kind, 1'b0));
                                    fin = 1'b1;
                                end else begin
                                    n_phase = wrsn_pkg::PH_PLO;
                                end
                            end
                            wrsn_pkg::PH_PSU: begin
                                g = push_rec(g, wrsn_pkg::mk_rec(wrsn_pkg::REC_PAIR,
                                    wrsn_pkg::suite_code(r_oui, r_b, wrsn_pkg::CIPHER_KNOWN),
                                    '0, r_kind, 1'b0));
                                n_sc = r_sc - 16'd1;
                                if (r_sc == 16'd1) begin
                                    if (len_x < next_x + CMP_W'(2))
                                        fin = 1'b1;
                                    else
                                        n_phase = wrsn_pkg::PH_ALO;
                                end
                            end
                            default: begin
                                g = push_rec(g, wrsn_pkg::mk_rec(wrsn_pkg::REC_AKM,
                                    wrsn_pkg::suite_code(r_oui, r_b, wrsn_pkg::AKM_KNOWN),
                                    '0, r_kind, 1'b0));
                                n_sc = r_sc - 16'd1;
                                if (r_sc == 16'd1)
                                    fin = 1'b1;
                            end
                        endcase
                    end
                end
                wrsn_pkg::PH_PHI: begin
                    if (len_x < next_x + cnt4_x) begin
                        fin = 1'b1;
                    end else if (cnt == 16'd0) begin
                        // empty pairwise list: key-management count must fit
                        if (len_x < next_x + CMP_W'(2))
                            fin = 1'b1;
                        else
                            n_phase = wrsn_pkg::PH_ALO;
                    end else begin
                        n_sc    = cnt;
                        n_phase = wrsn_pkg::PH_PSU;
                    end
                end
                wrsn_pkg::PH_AHI: begin
                    if (len_x < next_x + cnt4_x || cnt == 16'd0) begin
                        fin = 1'b1;
                    end else begin
                        n_sc    = cnt;
                        n_phase = wrsn_pkg::PH_ASU;
                    end
                end
                default: begin
                    n_phase = wrsn_pkg::PH_IDLE;
                end
            endcase
        end

        // End record closes the group
        if (fin) begin
            n_phase = wrsn_pkg::PH_IDLE;
            if (fin_rej)
                n_kind = wrsn_pkg::IK_NONE;
            g = push_rec(g, wrsn_pkg::mk_rec(wrsn_pkg::REC_END, wrsn_pkg::CODE_NONE, '0,
                                             fin_rej ? wrsn_pkg::IK_NONE : r_kind, 1'b1));
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bo    <= '0;
            r_len   <= '0;
            r_phase <= wrsn_pkg::PH_IDLE;
            r_kind  <= wrsn_pkg::IK_NONE;
            r_sc    <= '0;
            r_oui   <= 1'b1;
            r_low   <= '0;
        end else if (r_in_vld) begin
            r_bo    <= n_bo;
            r_len   <= n_len;
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_sc    <= n_sc;
            r_oui   <= n_oui;
            r_low   <= n_low;
        end
    end

    // Group queue: at most one group in per byte, one record out per word
    assign head  = r_grp[r_rp];
    assign push  = r_in_vld && (g.n != '0);
    assign pop   = o_out.valid && o_out.ready &&
                   ({1'b0, r_idx} == head.n - wrsn_pkg::REC_N_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (push)
                r_wp <= r_wp + PTR_W'(1);
            if (pop) begin
                r_rp  <= r_rp + PTR_W'(1);
                r_idx <= '0;
            end else if (o_out.valid && o_out.ready) begin
                r_idx <= r_idx + 2'd1;
            end
            r_cnt <= r_cnt + CNT_W'(push) - CNT_W'(pop);
        end
        if (push)
            r_grp[r_wp] <= g;
    end

    // Output word
    assign o_out.valid       = (r_cnt != '0);
    assign o_out.record_kind = head.rec[r_idx].kind;
    assign o_out.suite_code  = head.rec[r_idx].code;
    assign o_out.ie_version  = head.rec[r_idx].ver;
    assign o_out.ie_kind     = head.rec[r_idx].ikind;
    assign o_out.last_record = head.rec[r_idx].last;

endmodule
